[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the PLL setting search block.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion lbl failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion lbl failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/pps_pkg.sv]
// Package for the pixel PLL setting search: field widths, search constants
// and status codes. No dependencies.
`default_nettype none

package pps_pkg;

  localparam int PCLK_W    = 18;
  localparam int REF_W     = 16;
  localparam int WORD_W    = 32;
  localparam int STAT_W    = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam int PPS_MAX_N = 255;

  localparam logic [REF_W-1:0] REF_RESET = 16'd25000;
  localparam logic [REF_W-1:0] REM_LIMIT = 16'd16384;
  localparam int N_START   = 4;
  localparam int N_CAP     = 15;
  localparam int P_START   = 2;
  localparam int P_LAST    = 3;
  localparam int FRAC_SH   = 18;
  localparam int REM_KEEP  = WORD_W - FRAC_SH;
  localparam int FRAC_KEEP = WORD_W - 14;

  localparam logic [STAT_W-1:0] STAT_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EXHST = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SLOW  = 2'd2;

endpackage

`default_nettype wire

[sv/pixel_pll_setting_search.sv]
// Searches PLL divider settings (N, P, M, FRAC) for a wanted pixel clock
// against the programmed reference clock, one request at a time. Each trial
// passes the multiply state (S_MUL) and the M <= 1 check (S_CHK); a trial with M > 1
// adds one pass of the shared restoring divider (DW = 32 at the default MAX_N)
// plus the decision state (S_DEC), and a successful search adds one more
// divider pass for FRAC and the output state (S_OUT) that loads the result.
// The divider-bound path runs at most 13 divider trials. The longest search
// raises N past 15 both before and after P is raised. in_tready is high
// only between requests.
// Depends on pps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pixel_pll_setting_search #(
  parameter int MAX_N = pps_pkg::PPS_MAX_N
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [pps_pkg::IN_TDATA_W-1:0]   in_tdata,   // [17:0] pixel_clock_khz
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [pps_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [31:0] pll_word
  output logic [pps_pkg::STAT_W-1:0]       out_tuser,  // [1:0] status
  input  wire                              cfg_wr_en,
  input  wire  [pps_pkg::REF_W-1:0]        cfg_wr_data // [15:0] ref_clock_khz
);
  import pps_pkg::*;

  localparam int NW  = $clog2(MAX_N + 1);
  localparam int MW  = PCLK_W + NW;
  localparam int PW  = MW + 3;
  localparam int DW  = (PW > WORD_W) ? PW : WORD_W;
  localparam int CW  = $clog2(DW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [REF_W-1:0]  cfg_ref_r;
  logic              fphase_r, fphase_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  logic [PCLK_W-1:0] pclk_r, pclk_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [2:0]        p_r, p_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [REF_W-1:0]  rmd_r, rmd_nxt;
  logic [WORD_W-1:0] m_r, m_nxt;
  logic [FRAC_KEEP-1:0] frac_r, frac_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [WORD_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [STAT_W-1:0] out_tuser_r, out_tuser_nxt;

  logic [REF_W-1:0]  ref_eff;
  logic [MW-1:0]     mul;
  logic [REF_W:0]    trial;
  logic [REF_W:0]    diff;
  logic              ge;
  logic [WORD_W-1:0] word_sum;

  assign ref_eff  = (cfg_ref_r == '0) ? REF_W'(1) : cfg_ref_r;
  assign mul      = MW'(pclk_r) * MW'(n_r);
  assign trial    = {rmd_r, dvd_r[DW-1]};
  assign diff     = trial - {1'b0, ref_eff};
  assign ge       = (trial >= {1'b0, ref_eff});
  assign word_sum = {frac_r, 14'd0} + (WORD_W'(p_r) << 12) + (WORD_W'(n_r) << 8) + m_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    state_nxt      = state_r;
    fphase_nxt     = fphase_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    pclk_nxt       = pclk_r;
    n_nxt          = n_r;
    p_nxt          = p_r;
    prod_nxt       = prod_r;
    dvd_nxt        = dvd_r;
    rmd_nxt        = rmd_r;
    m_nxt          = m_r;
    frac_nxt       = frac_r;
    stat_nxt       = stat_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          pclk_nxt  = in_tdata[PCLK_W-1:0];
          n_nxt     = NW'(N_START);
          p_nxt     = 3'(P_START);
          frac_nxt  = '0;
          m_nxt     = '0;
          stat_nxt  = STAT_FOUND;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PW'(mul) << p_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (prod_r < PW'({ref_eff, 1'b0})) begin
          if (n_r >= NW'(MAX_N)) begin
            stat_nxt  = STAT_SLOW;
            state_nxt = S_OUT;
          end else begin
            n_nxt     = n_r + NW'(1);
            state_nxt = S_MUL;
          end
        end else begin
          dvd_nxt    = DW'(prod_r);
          rmd_nxt    = '0;
          cnt_nxt    = CW'(DW - 1);
          fphase_nxt = 1'b0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        rmd_nxt = ge ? diff[REF_W-1:0] : trial[REF_W-1:0];
        dvd_nxt = {dvd_r[DW-2:0], ge};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          if (fphase_r) begin
            frac_nxt  = dvd_nxt[FRAC_KEEP-1:0];
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DEC;
          end
        end
      end
      S_DEC: begin
        m_nxt = dvd_r[WORD_W-1:0];
        if (rmd_r > REM_LIMIT) begin
          if (n_r < NW'(N_CAP)) begin
            n_nxt     = n_r + NW'(1);
            state_nxt = S_MUL;
          end else begin
            n_nxt = NW'(N_CAP);
            p_nxt = p_r + 3'd1;
            if (p_r == 3'(P_LAST)) begin
              stat_nxt  = STAT_EXHST;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_MUL;
            end
          end
        end else begin
          dvd_nxt    = DW'({rmd_r[REM_KEEP-1:0], FRAC_SH'(0)});
          rmd_nxt    = '0;
          cnt_nxt    = CW'(DW - 1);
          fphase_nxt = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = (stat_r == STAT_SLOW) ? '0 : word_sum;
          out_tuser_nxt  = stat_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_ref_r    <= REF_RESET;
      fphase_r     <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fphase_r     <= fphase_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        cfg_ref_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pclk_r      <= pclk_nxt;
    n_r         <= n_nxt;
    p_r         <= p_nxt;
    prod_r      <= prod_nxt;
    dvd_r       <= dvd_nxt;
    rmd_r       <= rmd_nxt;
    m_r         <= m_nxt;
    frac_r      <= frac_nxt;
    stat_r      <= stat_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  `ASSERT_NEXT(a_start_mul, clk, rst_n, in_tvalid && in_tready, state_r == S_MUL)
  `ASSERT_IMPL(a_trial_range, clk, rst_n, state_r == S_MUL, p_r <= 3'(P_LAST) && n_r <= NW'(MAX_N))
  `ASSERT_NEXT(a_div_ends, clk, rst_n, state_r == S_DIV && cnt_r == '0, state_r != S_DIV)
  `ASSERT_IMPL(a_slow_zero, clk, rst_n, out_tvalid_r && out_tuser_r == STAT_SLOW, out_tdata_r == '0)
  `ASSERT_NEXT(a_out_wait, clk, rst_n, state_r == S_OUT && out_tvalid_r && !out_tready, state_r == S_OUT)

endmodule

`default_nettype wire

[bench/tb_pixel_pll_setting_search.sv]
// Self-checking bench for pixel_pll_setting_search: directed table, exhausting clocks, then
// random pixel clocks over several reference settings, each result checked against its
// table row or a local search. Depends on pps_pkg and the RTL of pixel_pll_setting_search.
`timescale 1ns / 100ps

module tb_pixel_pll_setting_search;
  import pps_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [STAT_W-1:0] stat;
  } pll_result_t;

  typedef struct packed {
    logic [REF_W-1:0]  ref_khz;
    logic [PCLK_W-1:0] pclk;
    logic              known;
    logic [WORD_W-1:0] word;
    logic [STAT_W-1:0] stat;
  } dir_row_t;

  localparam int N_DIR = 21;
  localparam int N_PHASE = 8;
  localparam int PHASE_ITEMS = 70;
  localparam logic [PCLK_W-1:0] PCLK_MAX = '1;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{16'd25000, 18'd25000,  1'b1, 32'h0000_2410, STAT_FOUND},
    '{16'd25000, 18'd100000, 1'b1, 32'h0000_2440, STAT_FOUND},
    '{16'd25000, 18'd0,      1'b1, 32'h0,         STAT_SLOW},
    '{16'd25000, 18'd1,      1'b1, 32'h0,         STAT_SLOW},
    '{16'd25000, 18'd262143, 1'b0, 32'h0,         STAT_FOUND},
    '{16'd25000, 18'd131072, 1'b0, 32'h0,         STAT_FOUND},
    '{16'd25000, 18'h15555,  1'b0, 32'h0,         STAT_FOUND},
    '{16'd25000, 18'h2AAAA,  1'b0, 32'h0,         STAT_FOUND},
    '{16'd1,     18'd262143, 1'b1, 32'h0040_23F0, STAT_FOUND},
    '{16'd1,     18'd1,      1'b1, 32'h0000_2410, STAT_FOUND},
    '{16'd1,     18'd0,      1'b1, 32'h0,         STAT_SLOW},
    '{16'd0,     18'd1,      1'b1, 32'h0000_2410, STAT_FOUND},
    '{16'd0,     18'd262143, 1'b1, 32'h0040_23F0, STAT_FOUND},
    '{16'd16385, 18'd16385,  1'b1, 32'h0000_2410, STAT_FOUND},
    '{16'd16385, 18'd262143, 1'b0, 32'h0,         STAT_FOUND},
    '{16'd65535, 18'd65535,  1'b1, 32'h0000_2410, STAT_FOUND},
    '{16'd65535, 18'd1,      1'b1, 32'h0,         STAT_SLOW},
    '{16'd65535, 18'd0,      1'b1, 32'h0,         STAT_SLOW},
    '{16'd65535, 18'd262143, 1'b0, 32'h0,         STAT_FOUND},
    '{16'd65535, 18'd1000,   1'b0, 32'h0,         STAT_FOUND},
    '{16'd65535, 18'd2000,   1'b0, 32'h0,         STAT_FOUND}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   cfg_wr_en;
  logic [REF_W-1:0]       cfg_wr_data;

  pll_result_t      pending_q[$];
  logic [REF_W-1:0] ref_now = REF_RESET;
  int               errors = 0;
  int               n_sent = 0;
  int               n_settings = 1;
  int               n_found = 0;
  int               n_exhst = 0;
  int               n_slow = 0;
  int               snd_idle = 25;
  int               rcv_idle = 78;
  bit               hold_req = 1'b0;
  int               hold_cnt = 0;

  pixel_pll_setting_search uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pll_result_t search_pll(input logic [PCLK_W-1:0] pclk,
                                             input logic [REF_W-1:0] ref_khz);
    longint unsigned pc, div, n, p, od, m, prod, rem, frac;
    pll_result_t     res;
    pc   = pclk;
    div  = (ref_khz == 0) ? 1 : ref_khz;
    n    = N_START;
    p    = P_START;
    od   = 1 << P_START;
    frac = 0;
    res.stat = STAT_FOUND;
    forever begin
      prod = pc * n * od;
      m    = prod / div;
      if (m <= 1) begin
        if (n >= PPS_MAX_N) begin
          res.word = '0;
          res.stat = STAT_SLOW;
          return res;
        end
        n++;
        continue;
      end
      rem = prod - div * m;
      if (rem > REM_LIMIT) begin
        if (n < N_CAP) begin
          n++;
        end else begin
          n  = N_CAP;
          p++;
          od = od * 2;
          if (p > P_LAST) begin
            res.stat = STAT_EXHST;
            break;
          end
        end
      end else begin
        frac = ((rem << FRAC_SH) & 64'hFFFF_FFFF) / div;
        break;
      end
    end
    res.word = WORD_W'(frac << 14) + WORD_W'(p << 12) + WORD_W'(n << 8) + WORD_W'(m);
    return res;
  endfunction

  task automatic send_pclk(input logic [PCLK_W-1:0] pclk, input bit known,
                           input pll_result_t want);
    while ($urandom_range(99, 0) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(pclk);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(known ? want : search_pll(pclk, ref_now));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ref(input logic [REF_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ref_now = value;
    n_settings++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else if (hold_req) begin
        out_tready <= 1'b0;
        hold_cnt = 400;
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    pll_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      case (out_tuser)
        STAT_FOUND: n_found++;
        STAT_EXHST: n_exhst++;
        STAT_SLOW:  n_slow++;
        default: ;
      endcase
      if (pending_q.size() == 0) begin
        $error("unexpected transfer: pll_word %h status %0d", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_tdata !== want.word) begin
          $error("pll_word: expected %h, actual %h", want.word, out_tdata);
          errors++;
        end
        if (out_tuser !== want.stat) begin
          $error("status: expected %0d, actual %0d", want.stat, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    #25_000_000;
    $display("pixel_pll_setting_search regression: fail");
    $finish;
  end

  initial begin
    dir_row_t         row;
    pll_result_t      r;
    pll_result_t      typed;
    logic [REF_W-1:0] phase_ref [N_PHASE];
    logic [PCLK_W-1:0] v;
    longint unsigned  t;
    int               hits;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      if (row.ref_khz != ref_now) begin
        wait_drained();
        write_ref(row.ref_khz);
      end
      typed.word = row.word;
      typed.stat = row.stat;
      send_pclk(row.pclk, row.known, typed);
    end

    // hunt for pixel clocks that run the search out at the top reference clock
    hits = 0;
    for (int c = 3000; c <= PCLK_MAX && hits < 3; c++) begin
      r = search_pll(PCLK_W'(c), ref_now);
      if (r.stat == STAT_EXHST) begin
        send_pclk(PCLK_W'(c), 1'b0, r);
        hits++;
      end
    end

    phase_ref = '{16'd25000, 16'd65535, 16'd1, 16'd0, 16'd27000, 16'd16385,
                  REF_W'($urandom_range(65535, 2)), REF_W'($urandom_range(65535, 2))};
    for (int ph = 0; ph < N_PHASE; ph++) begin
      wait_drained();
      write_ref(phase_ref[ph]);
      if (ph < 3) begin
        snd_idle = 25;
        rcv_idle = 78;
      end else if (ph < 6) begin
        snd_idle = 78;
        rcv_idle = 25;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 5) hold_req = 1'b1;
        if (ph == 4 && k == 35) wait_drained();
        case ($urandom_range(9, 0))
          0, 1, 2, 3: v = PCLK_W'($urandom_range(PCLK_MAX, 1));
          4, 5: begin
            t = (longint'(ref_now) * $urandom_range(64, 1)) / 16 + $urandom_range(3, 0);
            v = (t > PCLK_MAX) ? PCLK_MAX : PCLK_W'(t);
          end
          6, 7: v = PCLK_W'($urandom_range(3000, 1));
          8: begin
            case ($urandom_range(3, 0))
              0: v = 18'd1;
              1: v = PCLK_MAX;
              2: v = 18'h20000;
              default: v = 18'h1FFFF;
            endcase
          end
          default: v = PCLK_W'($urandom);
        endcase
        send_pclk(v, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (600) @(negedge clk);

    $display("%0d pixel clocks over %0d reference settings, incl. a 400-cycle output stall",
             n_sent, n_settings);
    $display("results seen: %0d found, %0d exhausted, %0d too slow",
             n_found, n_exhst, n_slow);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("pixel_pll_setting_search regression: pass");
    end else begin
      $display("pixel_pll_setting_search regression: fail");
    end
    $finish;
  end

endmodule
